// ===== rtl/lfkd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfkd_pkg
// Types and constants shared by the leapfrog kick-drift update pipeline.
// ----------------------------------------------------------------------------
package lfkd_pkg;

    // Number of register stages from input beat to result beat
    localparam int LATENCY = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_FLOOR_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_FLOOR_3 = 3'd5;

    // Register widths and reset values
    localparam int TIME_STEP_W = 32;
    localparam int DAMPING_W   = 17;
    localparam int ENERGY_W    = 31;
    localparam int MAT_W       = 2;

    localparam logic [TIME_STEP_W-1:0] TIME_STEP_RST = 32'd65536;
    localparam logic [DAMPING_W-1:0]   DAMPING_RST   = 17'd65536;

    // Saturation bounds on a wide signed intermediate
    localparam logic signed [65:0] S32_MAX_W = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] S32_MIN_W = -66'sh0_8000_0000;

    typedef struct packed {
        logic signed [31:0]   pos_x;
        logic signed [31:0]   pos_y;
        logic signed [31:0]   pos_z;
        logic signed [31:0]   vel_x;
        logic signed [31:0]   vel_y;
        logic signed [31:0]   vel_z;
        logic signed [31:0]   accel_x;
        logic signed [31:0]   accel_y;
        logic signed [31:0]   accel_z;
        logic [ENERGY_W-1:0]  energy;
        logic signed [31:0]   energy_rate;
        logic [MAT_W-1:0]     material_sel;
    } t_particle_in;

    typedef struct packed {
        logic signed [31:0]   next_pos_x;
        logic signed [31:0]   next_pos_y;
        logic signed [31:0]   next_pos_z;
        logic signed [31:0]   next_vel_x;
        logic signed [31:0]   next_vel_y;
        logic signed [31:0]   next_vel_z;
        logic [ENERGY_W-1:0]  next_energy;
    } t_particle_out;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat_s32(input logic signed [65:0] x);
        logic signed [31:0] res;
        if (x > S32_MAX_W) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < S32_MIN_W) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/lfkd_axis.sv =====
// ----------------------------------------------------------------------------
// lfkd_axis
// One axis of the update: half kick, damping, drift. Six register stages,
// one multiplier each in stages one, three and five.
// ----------------------------------------------------------------------------
module lfkd_axis (
    input  logic                                  i_clk,
    input  logic signed [31:0]                    i_pos,
    input  logic signed [31:0]                    i_vel,
    input  logic signed [31:0]                    i_accel,
    input  logic [lfkd_pkg::TIME_STEP_W-1:0]      i_time_step,
    input  logic [lfkd_pkg::DAMPING_W-1:0]        i_damping,
    output logic signed [31:0]                    o_pos,
    output logic signed [31:0]                    o_vel
);

    logic signed [64:0] r_kick_prod;
    logic signed [49:0] r_damp_prod;
    logic signed [64:0] r_drift_prod;
    logic signed [31:0] r_vel1;
    logic signed [31:0] r_vel2;
    logic signed [31:0] r_vel4;
    logic signed [31:0] r_vel5;
    logic signed [31:0] r_vel6;
    logic signed [31:0] r_pos_dly [1:5];
    logic signed [31:0] r_pos6;

    logic signed [64:0] n_kick;
    logic signed [49:0] n_damped;
    logic signed [64:0] n_drift;

    // Products are floored by arithmetic shifts
    always_comb begin
        n_kick   = r_kick_prod >>> 17;
        n_damped = r_damp_prod >>> 16;
        n_drift  = r_drift_prod >>> 16;
    end

    // Advance the datapath every cycle
    always_ff @(posedge i_clk) begin
        // stage 1: a * dt
        r_kick_prod  <= i_accel * $signed({1'b0, i_time_step});
        r_vel1       <= i_vel;
        r_pos_dly[1] <= i_pos;
        // stage 2: add half kick, saturate
        r_vel2       <= lfkd_pkg::sat_s32(66'(r_vel1) + 66'(n_kick));
        r_pos_dly[2] <= r_pos_dly[1];
        // stage 3: v * damping
        r_damp_prod  <= r_vel2 * $signed({1'b0, i_damping});
        r_pos_dly[3] <= r_pos_dly[2];
        // stage 4: rescale damped velocity, saturate
        r_vel4       <= lfkd_pkg::sat_s32(66'(n_damped));
        r_pos_dly[4] <= r_pos_dly[3];
        // stage 5: v * dt
        r_drift_prod <= r_vel4 * $signed({1'b0, i_time_step});
        r_vel5       <= r_vel4;
        r_pos_dly[5] <= r_pos_dly[4];
        // stage 6: drift position, saturate
        r_pos6       <= lfkd_pkg::sat_s32(66'(r_pos_dly[5]) + 66'(n_drift));
        r_vel6       <= r_vel5;
    end

    assign o_pos = r_pos6;
    assign o_vel = r_vel6;

endmodule

// ===== rtl/leapfrog_kick_drift_update.sv =====
// ----------------------------------------------------------------------------
// leapfrog_kick_drift_update
// Leapfrog half kick, velocity damping, energy kick with per-material floor
// and position drift for one particle record per beat, Q16.16 saturating.
// ----------------------------------------------------------------------------
// A new particle may be started in every clock cycle; o_busy is always low.
// Each result appears on o_result with o_valid high for one cycle, in order,
// after the six register stages of the kick-multiply, damping-multiply and
// drift-multiply chain. The receiver must take every result beat in that
// cycle. Write registers only while no particle is in flight.
// ----------------------------------------------------------------------------
module leapfrog_kick_drift_update #(
    parameter int NUM_MATERIALS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  lfkd_pkg::t_particle_in             i_item,
    output logic                               o_valid,
    output lfkd_pkg::t_particle_out            o_result,
    input  logic                               i_cfg_we,
    input  logic [lfkd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lfkd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SEL_W = (NUM_MATERIALS > 1) ? $clog2(NUM_MATERIALS) : 1;
    localparam logic [2:0] NUM_MAT_C = 3'(NUM_MATERIALS);
    localparam int LAT = lfkd_pkg::LATENCY;

    logic [lfkd_pkg::TIME_STEP_W-1:0] r_time_step;
    logic [lfkd_pkg::DAMPING_W-1:0]   r_damping;
    logic [lfkd_pkg::ENERGY_W-1:0]    r_energy_floor [NUM_MATERIALS];
    logic [LAT-1:0]                   r_valid;

    logic signed [64:0]               r_erate_prod;
    logic [lfkd_pkg::ENERGY_W-1:0]    r_energy1;
    logic [lfkd_pkg::ENERGY_W-1:0]    r_floor1;
    logic [lfkd_pkg::ENERGY_W-1:0]    r_energy_dly [2:LAT];

    logic                             accept;
    logic [2:0]                       n_floor_idx;
    logic [2:0]                       n_sel_wide;
    logic [SEL_W-1:0]                 n_sel;
    logic signed [64:0]               n_ekick;
    logic signed [65:0]               n_energy_sum;
    logic signed [65:0]               n_energy_flr;
    logic [lfkd_pkg::ENERGY_W-1:0]    n_energy;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // Configuration registers
    assign n_floor_idx = i_cfg_idx - lfkd_pkg::REG_ENERGY_FLOOR_0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= lfkd_pkg::TIME_STEP_RST;
            r_damping   <= lfkd_pkg::DAMPING_RST;
            for (int k = 0; k < NUM_MATERIALS; k++) begin
                r_energy_floor[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lfkd_pkg::REG_TIME_STEP) begin
                r_time_step <= i_cfg_data[lfkd_pkg::TIME_STEP_W-1:0];
            end else if (i_cfg_idx == lfkd_pkg::REG_DAMPING) begin
                r_damping <= i_cfg_data[lfkd_pkg::DAMPING_W-1:0];
            end else if (i_cfg_idx >= lfkd_pkg::REG_ENERGY_FLOOR_0 &&
                         i_cfg_idx <= lfkd_pkg::REG_ENERGY_FLOOR_3 &&
                         n_floor_idx < NUM_MAT_C) begin
                r_energy_floor[SEL_W'(n_floor_idx)] <=
                    i_cfg_data[lfkd_pkg::ENERGY_W-1:0];
            end
        end
    end

    // Advance valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[LAT-2:0], accept};
        end
    end

    // Three axis lanes
    lfkd_axis u_axis_x (
        .i_clk       (i_clk),
        .i_pos       (i_item.pos_x),
        .i_vel       (i_item.vel_x),
        .i_accel     (i_item.accel_x),
        .i_time_step (r_time_step),
        .i_damping   (r_damping),
        .o_pos       (o_result.next_pos_x),
        .o_vel       (o_result.next_vel_x)
    );

    lfkd_axis u_axis_y (
        .i_clk       (i_clk),
        .i_pos       (i_item.pos_y),
        .i_vel       (i_item.vel_y),
        .i_accel     (i_item.accel_y),
        .i_time_step (r_time_step),
        .i_damping   (r_damping),
        .o_pos       (o_result.next_pos_y),
        .o_vel       (o_result.next_vel_y)
    );

    lfkd_axis u_axis_z (
        .i_clk       (i_clk),
        .i_pos       (i_item.pos_z),
        .i_vel       (i_item.vel_z),
        .i_accel     (i_item.accel_z),
        .i_time_step (r_time_step),
        .i_damping   (r_damping),
        .o_pos       (o_result.next_pos_z),
        .o_vel       (o_result.next_vel_z)
    );

    // Clamp the material selector to the last configured material
    always_comb begin
        n_sel_wide = ({1'b0, i_item.material_sel} >= NUM_MAT_C) ?
                     (NUM_MAT_C - 3'd1) : {1'b0, i_item.material_sel};
        n_sel      = SEL_W'(n_sel_wide);
    end

    // Energy kick, floor and clamp
    always_comb begin
        n_ekick      = r_erate_prod >>> 17;
        n_energy_sum = 66'($signed({1'b0, r_energy1})) + 66'(n_ekick);
        n_energy_flr = (n_energy_sum < 66'($signed({1'b0, r_floor1}))) ?
                       66'($signed({1'b0, r_floor1})) : n_energy_sum;
        if (n_energy_flr < 66'sd0) begin
            n_energy = '0;
        end else if (n_energy_flr > 66'sh0_7FFF_FFFF) begin
            n_energy = '1;
        end else begin
            n_energy = n_energy_flr[lfkd_pkg::ENERGY_W-1:0];
        end
    end

    // Energy lane: multiply, kick, then hold until the axes finish
    always_ff @(posedge i_clk) begin
        r_erate_prod    <= i_item.energy_rate * $signed({1'b0, r_time_step});
        r_energy1       <= i_item.energy;
        r_floor1        <= r_energy_floor[n_sel];
        r_energy_dly[2] <= n_energy;
        for (int k = 3; k <= LAT; k++) begin
            r_energy_dly[k] <= r_energy_dly[k-1];
        end
    end

    assign o_result.next_energy = r_energy_dly[LAT];
    assign o_valid              = r_valid[LAT-1];

    // Every result beat comes from a matching earlier start beat
    a_result_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 6))
        else $error("result beat without matching start beat");

    // Every start beat with no reset since yields a result beat
    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(accept, 6) && $past(i_rst_n, 1) && $past(i_rst_n, 2) &&
        $past(i_rst_n, 3) && $past(i_rst_n, 4) && $past(i_rst_n, 5) &&
        $past(i_rst_n, 6) |-> o_valid)
        else $error("start beat lost in pipeline");

    // Kicked energy of a valid beat never sits below the floor it was paired with
    a_energy_nonneg_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] |-> r_energy_dly[2] >= $past(r_floor1))
        else $error("energy below selected floor");

endmodule

// ===== verif/tb_leapfrog_kick_drift_update.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_leapfrog_kick_drift_update
// Self-checking bench for the leapfrog kick-drift pipeline. Particle beats are
// sent with random gaps under a series of step, damping and energy floor
// settings; each result beat is compared field by field against a Q16.16
// saturating predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_leapfrog_kick_drift_update;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int MAX_GAP         = 5;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int NUM_MATERIALS   = 4;
    localparam int PHASE_COUNT     = 10;
    localparam int ITEMS_PER_PHASE = 152;
    localparam int KICK_SHIFT      = 17;
    localparam int FRAC_BITS       = 16;

    localparam logic [lfkd_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST =
        lfkd_pkg::REG_ENERGY_FLOOR_3 + 3'd1;
    localparam logic [lfkd_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    localparam logic [31:0] S32_MAX_WORD = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN_WORD = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
    localparam logic [31:0] ENERGY_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] DAMP_UNITY   = 32'h0001_0000;
    localparam logic [31:0] DAMP_FIELD   = 32'h0001_FFFF;
    localparam longint      S32_HI       = 64'sd2147483647;
    localparam longint      S32_LO       = -64'sd2147483648;
    localparam longint      U31_HI       = 64'sd2147483647;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    lfkd_pkg::t_particle_in   i_item;
    logic                     o_valid;
    lfkd_pkg::t_particle_out  o_result;
    logic                     i_cfg_we;
    logic [lfkd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lfkd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the register file
    logic [lfkd_pkg::TIME_STEP_W-1:0] step_q16;
    logic [lfkd_pkg::DAMPING_W-1:0]   damp_q16;
    logic [lfkd_pkg::ENERGY_W-1:0]    floor_q16 [NUM_MATERIALS];

    lfkd_pkg::t_particle_out next_state_q[$];
    int            error_count = 0;
    int            idle_cycles = 0;

    leapfrog_kick_drift_update #(
        .NUM_MATERIALS(NUM_MATERIALS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_s32(input longint x);
        if (x > S32_HI) begin
            return S32_HI;
        end
        if (x < S32_LO) begin
            return S32_LO;
        end
        return x;
    endfunction

    // Half kick, damp, drift and energy kick for one particle beat
    function automatic lfkd_pkg::t_particle_out integrate_particle(
        input lfkd_pkg::t_particle_in p);
        lfkd_pkg::t_particle_out r;
        longint dt;
        longint damp;
        longint fl;
        longint nrg;
        longint pos [3];
        longint vel [3];
        longint acc [3];
        int     sel;
        dt     = longint'(step_q16);
        damp   = longint'(damp_q16);
        pos[0] = longint'($signed(p.pos_x));
        pos[1] = longint'($signed(p.pos_y));
        pos[2] = longint'($signed(p.pos_z));
        vel[0] = longint'($signed(p.vel_x));
        vel[1] = longint'($signed(p.vel_y));
        vel[2] = longint'($signed(p.vel_z));
        acc[0] = longint'($signed(p.accel_x));
        acc[1] = longint'($signed(p.accel_y));
        acc[2] = longint'($signed(p.accel_z));
        for (int k = 0; k < 3; k++) begin
            vel[k] = clamp_s32(vel[k] + ((acc[k] * dt) >>> KICK_SHIFT));
            vel[k] = clamp_s32((vel[k] * damp) >>> FRAC_BITS);
            pos[k] = clamp_s32(pos[k] + ((vel[k] * dt) >>> FRAC_BITS));
        end
        r.next_pos_x = pos[0][31:0];
        r.next_pos_y = pos[1][31:0];
        r.next_pos_z = pos[2][31:0];
        r.next_vel_x = vel[0][31:0];
        r.next_vel_y = vel[1][31:0];
        r.next_vel_z = vel[2][31:0];

        // Fall back to the last material for an out-of-range selector
        sel = int'(p.material_sel);
        if (sel >= NUM_MATERIALS) begin
            sel = NUM_MATERIALS - 1;
        end
        fl  = longint'(floor_q16[sel]);
        nrg = longint'(p.energy) + ((longint'($signed(p.energy_rate)) * dt) >>> KICK_SHIFT);
        if (nrg < fl) begin
            nrg = fl;
        end
        if (nrg < 0) begin
            nrg = 0;
        end
        if (nrg > U31_HI) begin
            nrg = U31_HI;
        end
        r.next_energy = nrg[lfkd_pkg::ENERGY_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_result
        lfkd_pkg::t_particle_out want;
        if (i_rst_n && o_valid) begin
            if (next_state_q.size() == 0) begin
                error_count++;
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, o_result);
            end else begin
                want = next_state_q.pop_front();
                compare_field("next_pos_x", want.next_pos_x, o_result.next_pos_x);
                compare_field("next_pos_y", want.next_pos_y, o_result.next_pos_y);
                compare_field("next_pos_z", want.next_pos_z, o_result.next_pos_z);
                compare_field("next_vel_x", want.next_vel_x, o_result.next_vel_x);
                compare_field("next_vel_y", want.next_vel_y, o_result.next_vel_y);
                compare_field("next_vel_z", want.next_vel_z, o_result.next_vel_z);
                compare_field("next_energy", {1'b0, want.next_energy},
                              {1'b0, o_result.next_energy});
            end
        end
    end

    // Abort when no beat of any kind moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [lfkd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lfkd_pkg::REG_TIME_STEP) begin
            step_q16 = data;
        end else if (idx == lfkd_pkg::REG_DAMPING) begin
            damp_q16 = data[lfkd_pkg::DAMPING_W-1:0];
        end else if (idx >= lfkd_pkg::REG_ENERGY_FLOOR_0 &&
                     idx <= lfkd_pkg::REG_ENERGY_FLOOR_3) begin
            floor_q16[idx - lfkd_pkg::REG_ENERGY_FLOOR_0] = data[lfkd_pkg::ENERGY_W-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] dt, input logic [31:0] damp,
                             input logic [31:0] f0, input logic [31:0] f1,
                             input logic [31:0] f2, input logic [31:0] f3);
        write_reg(lfkd_pkg::REG_TIME_STEP, dt);
        write_reg(lfkd_pkg::REG_DAMPING, damp);
        write_reg(lfkd_pkg::REG_ENERGY_FLOOR_0, f0);
        write_reg(lfkd_pkg::REG_ENERGY_FLOOR_0 + 3'd1, f1);
        write_reg(lfkd_pkg::REG_ENERGY_FLOOR_0 + 3'd2, f2);
        write_reg(lfkd_pkg::REG_ENERGY_FLOOR_3, f3);
    endtask

    // Hold start low until every pending result beat has come back
    task automatic drain_pipeline();
        i_start <= 1'b0;
        while (next_state_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (lfkd_pkg::LATENCY) @(posedge i_clk);
    endtask

    task automatic send_particle(input lfkd_pkg::t_particle_in p, input int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= p;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        next_state_q = {next_state_q, integrate_particle(p)};
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic lfkd_pkg::t_particle_in particle_uniform(
        input logic [31:0] pos, input logic [31:0] vel, input logic [31:0] acc,
        input logic [31:0] nrg, input logic [31:0] rate, input logic [1:0] sel);
        lfkd_pkg::t_particle_in p;
        p.pos_x        = pos;
        p.pos_y        = pos;
        p.pos_z        = pos;
        p.vel_x        = vel;
        p.vel_y        = vel;
        p.vel_z        = vel;
        p.accel_x      = acc;
        p.accel_y      = acc;
        p.accel_z      = acc;
        p.energy       = nrg[lfkd_pkg::ENERGY_W-1:0];
        p.energy_rate  = rate;
        p.material_sel = sel;
        return p;
    endfunction

    // Mix of full-range, moderate, boundary and power-of-two magnitudes
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = $urandom;
            4, 5, 6, 7: w = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            8: begin
                case ($urandom_range(0, 3))
                    0:       w = S32_MAX_WORD;
                    1:       w = S32_MIN_WORD;
                    2:       w = '0;
                    default: w = '1;
                endcase
            end
            default: begin
                w = ONE_Q16 << $urandom_range(0, 14);
                if ($urandom_range(0, 1) == 1) begin
                    w = -w;
                end
            end
        endcase
        return w;
    endfunction

    function automatic lfkd_pkg::t_particle_in random_particle();
        lfkd_pkg::t_particle_in p;
        logic [31:0]  w;
        p.pos_x       = random_word();
        p.pos_y       = random_word();
        p.pos_z       = random_word();
        p.vel_x       = random_word();
        p.vel_y       = random_word();
        p.vel_z       = random_word();
        p.accel_x     = random_word();
        p.accel_y     = random_word();
        p.accel_z     = random_word();
        p.energy_rate = random_word();
        w = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 32'h00FF_FFFF) : random_word();
        p.energy       = w[lfkd_pkg::ENERGY_W-1:0];
        p.material_sel = lfkd_pkg::MAT_W'($urandom_range(0, 3));
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Run with the settings left by reset: unit step, unit damping, no floors
    task automatic test_reset_config();
        send_particle(particle_uniform('0, '0, '0, '0, '0, 2'd0), 0);
        send_particle(particle_uniform(ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, 2'd1), 0);
        send_particle(particle_uniform(32'h0003_8000, -32'h0001_4000, 32'h0000_2000,
                                       32'h0010_0000, -32'h0000_8000, 2'd2), 2);
    endtask

    // Drive every field to its limits, including a kick that takes energy negative
    task automatic test_field_extremes();
        lfkd_pkg::t_particle_in p;
        send_particle(particle_uniform(S32_MAX_WORD, S32_MAX_WORD, S32_MAX_WORD,
                                       ENERGY_MAX, S32_MAX_WORD, 2'd0), 0);
        send_particle(particle_uniform(S32_MIN_WORD, S32_MIN_WORD, S32_MIN_WORD,
                                       '0, S32_MIN_WORD, 2'd1), 1);
        send_particle(particle_uniform(S32_MAX_WORD, ONE_Q16, '0, '0, '0, 2'd2), 0);
        send_particle(particle_uniform(S32_MIN_WORD, -ONE_Q16, '0, 32'd1, '1, 2'd3), 3);
        // Odd negative products round toward minus infinity
        p = particle_uniform('0, '0, '1, 32'd1, 32'hFFFF_FFFD, 2'd0);
        p.vel_y = S32_MAX_WORD;
        p.accel_z = S32_MIN_WORD;
        send_particle(p, 0);
        drain_pipeline();
        write_reg(lfkd_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
        send_particle(particle_uniform(32'h1234_5678, 32'hFFFF_0001, 32'h0000_0003,
                                       32'h7FFF_0000, 32'h0000_0007, 2'd1), 0);
        drain_pipeline();
        write_reg(lfkd_pkg::REG_TIME_STEP, '0);
        send_particle(particle_uniform(S32_MIN_WORD, S32_MAX_WORD, S32_MIN_WORD,
                                       32'h0000_1000, S32_MIN_WORD, 2'd2), 0);
        drain_pipeline();
    endtask

    // Give each material its own floor and push energy below it
    task automatic test_material_floors();
        configure(ONE_Q16, DAMP_UNITY, 32'h0000_1000, 32'h0002_0000, 32'h4000_0000,
                  ENERGY_MAX);
        for (int m = 0; m < NUM_MATERIALS; m++) begin
            send_particle(particle_uniform(ONE_Q16, ONE_Q16, '0, '0, -ONE_Q16,
                                           lfkd_pkg::MAT_W'(m)),
                          m % 2);
        end
        send_particle(particle_uniform('0, '0, '0, 32'h5000_0000, ONE_Q16, 2'd2), 0);
        drain_pipeline();
    endtask

    // Damping factors at zero and above one
    task automatic test_damping_gain();
        configure(32'h0000_8000, DAMP_FIELD, '0, '0, '0, '0);
        send_particle(particle_uniform(ONE_Q16, 32'h4000_0000, 32'h0100_0000,
                                       ONE_Q16, '0, 2'd0), 0);
        drain_pipeline();
        write_reg(lfkd_pkg::REG_DAMPING, DAMP_UNITY + 32'd1);
        send_particle(particle_uniform('0, -32'h0123_4567, ONE_Q16, '0, '0, 2'd3), 0);
        drain_pipeline();
        write_reg(lfkd_pkg::REG_DAMPING, '0);
        send_particle(particle_uniform(ONE_Q16, S32_MAX_WORD, S32_MAX_WORD, ONE_Q16,
                                       ONE_Q16, 2'd1), 0);
        drain_pipeline();
    endtask

    // Writes to unmapped indexes must leave the register file alone
    task automatic test_unknown_register();
        for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++) begin
            write_reg(lfkd_pkg::CFG_IDX_W'(idx), $urandom);
        end
        send_particle(particle_uniform(32'h0007_0000, 32'h0002_0000, -32'h0004_0000,
                                       32'h0001_0000, -32'h0003_0000, 2'd0), 0);
        drain_pipeline();
    endtask

    // Random records under a sequence of register settings, extremes first
    task automatic test_random_phases();
        logic [31:0] dt;
        logic [31:0] damp;
        logic [31:0] fl [NUM_MATERIALS];
        bit          burst;
        int          gap;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            for (int m = 0; m < NUM_MATERIALS; m++) begin
                fl[m] = $urandom_range(0, 1) ? $urandom_range(0, 32'h000F_FFFF) : $urandom;
            end
            case (phase)
                0: begin
                    dt = '0;
                    damp = DAMP_UNITY;
                    for (int m = 0; m < NUM_MATERIALS; m++) fl[m] = '0;
                end
                1: begin
                    dt = 32'hFFFF_FFFF;
                    damp = DAMP_FIELD;
                    for (int m = 0; m < NUM_MATERIALS; m++) fl[m] = ENERGY_MAX;
                end
                2: begin
                    dt = ONE_Q16;
                    damp = '0;
                end
                3: begin
                    dt = $urandom_range(1, 32'h0000_FFFF);
                    damp = $urandom_range(0, DAMP_UNITY);
                end
                default: begin
                    dt = $urandom_range(0, 1) ? $urandom_range(0, 32'h0002_0000) : $urandom;
                    damp = $urandom_range(0, 1) ? $urandom_range(32'h0000_F000, DAMP_UNITY)
                                                 : $urandom;
                end
            endcase
            // Pause until the pipe is empty before touching the registers
            drain_pipeline();
            configure(dt, damp, fl[0], fl[1], fl[2], fl[3]);
            burst = 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 25 == 0) begin
                    burst = ($urandom_range(0, 3) == 0);
                end
                gap = burst ? 0 : $urandom_range(0, MAX_GAP);
                send_particle(random_particle(), gap);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        step_q16 = lfkd_pkg::TIME_STEP_RST;
        damp_q16 = lfkd_pkg::DAMPING_RST;
        for (int m = 0; m < NUM_MATERIALS; m++) begin
            floor_q16[m] = '0;
        end
        i_rst_n    <= 1'b0;
        i_start    <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_field_extremes();
        test_material_floors();
        test_damping_gain();
        test_unknown_register();
        test_random_phases();
        drain_pipeline();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
